// ----- hw/rtl/rabt_pkg.sv -----
`timescale 1ns / 1ps

package rabt_pkg;

  // time values and registers are kept in this many bits
  localparam int TIME_BITS = 16;
  localparam int PER_W     = TIME_BITS + 1;      // on + off
  localparam int TOT_W     = 2 * TIME_BITS + 2;  // total length, overall timer
  localparam int TMR_W     = TIME_BITS + 2;      // phase timers, dividend
  localparam int TALLY_W   = 32;
  localparam int UNIT_W    = TOT_W;              // shared adder width
  localparam int STEP_W    = $clog2(TMR_W + 1);
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // register indexes (word address)
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_ON    = 2'd1;
  localparam logic [1:0] REG_OFF   = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] count;
    logic [TIME_BITS-1:0] on;
    logic [TIME_BITS-1:0] off;
  } cfg_t;

  typedef struct packed {
    logic               setup_valid;
    logic [TALLY_W-1:0] plays_done;
    logic               playing;
    logic               active;
  } result_t;

endpackage

// ----- hw/rtl/rabt_unit.sv -----
`timescale 1ns / 1ps

// Shared shift-and-add unit: one bit of a multiply or a restoring divide per cycle.
module rabt_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rabt_pkg::unit_req_t              req_i,
  input  logic [rabt_pkg::UNIT_W-1:0]      opa_i,   // multiplicand or divisor
  input  logic [rabt_pkg::TMR_W-1:0]       opb_i,   // multiplier or dividend
  output rabt_pkg::unit_sts_t              sts_o,
  output logic [rabt_pkg::UNIT_W-1:0]      acc_o,   // product or remainder
  output logic [rabt_pkg::TMR_W-1:0]       bits_o   // quotient
);

  localparam int UW = rabt_pkg::UNIT_W;
  localparam int BW = rabt_pkg::TMR_W;
  localparam int SW = rabt_pkg::STEP_W;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  rabt_pkg::unit_op_e  op_q, op_d;
  logic [SW-1:0]       cnt_q, cnt_d;
  logic [UW-1:0]       acc_q, acc_d;
  logic [UW-1:0]       opnd_q, opnd_d;
  logic [BW-1:0]       bits_q, bits_d;

  logic                is_div;
  logic [UW-1:0]       a_in;
  logic [UW:0]         sum;

  assign is_div = (op_q == rabt_pkg::OP_DIV);
  // for a divide, bring down the next dividend bit into the partial remainder
  assign a_in   = is_div ? {acc_q[UW-2:0], bits_q[BW-1]} : acc_q;
  assign sum    = is_div ? ({1'b0, a_in} - {1'b0, opnd_q})
                         : ({1'b0, a_in} + {1'b0, opnd_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opnd_d = opnd_q;
    bits_d = bits_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = '0;
      opnd_d = opa_i;
      bits_d = opb_i;
      cnt_d  = (req_i.op == rabt_pkg::OP_DIV) ? SW'(BW) : SW'(rabt_pkg::TIME_BITS);
    end else if (busy_q) begin
      if (is_div) begin
        // borrow means the trial subtract failed: keep the shifted remainder
        acc_d  = sum[UW] ? a_in : sum[UW-1:0];
        bits_d = {bits_q[BW-2:0], ~sum[UW]};
      end else begin
        if (bits_q[0]) begin
          acc_d = sum[UW-1:0];
        end
        opnd_d = {opnd_q[UW-2:0], 1'b0};
        bits_d = {1'b0, bits_q[BW-1:1]};
      end
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= rabt_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    bits_q <= bits_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;
  assign bits_o     = bits_q;

endmodule

// ----- hw/rtl/rabt_core.sv -----
`timescale 1ns / 1ps

module rabt_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               item_valid_i,
  output logic                               item_ready_o,
  input  logic                               cmd_i,
  input  logic [rabt_pkg::TIME_BITS-1:0]     elapsed_i,
  input  rabt_pkg::cfg_t                     cfg_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output rabt_pkg::result_t                  res_o
);

  localparam int TB = rabt_pkg::TIME_BITS;
  localparam int TM = rabt_pkg::TMR_W;
  localparam int TT = rabt_pkg::TOT_W;
  localparam int UW = rabt_pkg::UNIT_W;
  localparam int TW = rabt_pkg::TALLY_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_TOTAL = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_FOLD  = 8'b0010_0000,
    S_OVER  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic            active_q, active_d;
  logic            playing_q, playing_d;
  logic            valid_q, valid_d;
  logic [TT-1:0]   total_q, total_d;
  logic [TT-1:0]   overall_q, overall_d;
  logic [TM-1:0]   on_tmr_q, on_tmr_d;
  logic [TM-1:0]   off_tmr_q, off_tmr_d;
  logic [TW-1:0]   tally_q, tally_d;
  logic [TB-1:0]   lat_on_q, lat_on_d;
  logic [TB-1:0]   lat_off_q, lat_off_d;
  logic [TB-1:0]   dt_q, dt_d;

  rabt_pkg::unit_req_t  req;
  rabt_pkg::unit_sts_t  sts;
  logic [UW-1:0]        unit_acc;
  logic [TM-1:0]        unit_bits;
  logic [UW-1:0]        opa;
  logic [TM-1:0]        opb;

  logic                 in_idle;
  logic [TB-1:0]        src_on, src_off;
  logic [rabt_pkg::PER_W-1:0] period;
  logic [TM-1:0]        phase_sum;
  logic [TM-1:0]        phase_lim;
  logic [TM-1:0]        rem;
  logic                 cross_on, cross_off;
  logic [TT-1:0]        tot_diff;
  logic [TT:0]          over_sum;

  assign in_idle   = (state_q == S_IDLE);
  assign src_on    = in_idle ? cfg_i.on  : lat_on_q;
  assign src_off   = in_idle ? cfg_i.off : lat_off_q;
  assign period    = {1'b0, src_on} + {1'b0, src_off};
  assign phase_sum = (playing_q ? on_tmr_q : off_tmr_q) + TM'(dt_q);
  assign phase_lim = playing_q ? TM'(lat_on_q) : TM'(lat_off_q);
  assign rem       = unit_acc[TM-1:0];
  assign cross_on  = (rem >= TM'(lat_on_q));
  assign cross_off = (rem >= TM'(lat_off_q));
  assign tot_diff  = unit_acc[TT-1:0] - TT'(lat_off_q);
  assign over_sum  = {1'b0, overall_q} + (TT + 1)'(dt_q);

  assign opa = UW'(period);
  assign opb = in_idle ? TM'(cfg_i.count) : phase_sum;

  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    playing_d = playing_q;
    valid_d   = valid_q;
    total_d   = total_q;
    overall_d = overall_q;
    on_tmr_d  = on_tmr_q;
    off_tmr_d = off_tmr_q;
    tally_d   = tally_q;
    lat_on_d  = lat_on_q;
    lat_off_d = lat_off_q;
    dt_d      = dt_q;
    req.start = 1'b0;
    req.op    = rabt_pkg::OP_MUL;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          if (cmd_i) begin
            active_d  = 1'b0;
            playing_d = 1'b0;
            total_d   = '0;
            overall_d = '0;
            on_tmr_d  = '0;
            off_tmr_d = '0;
            tally_d   = '0;
            lat_on_d  = cfg_i.on;
            lat_off_d = cfg_i.off;
            valid_d   = (cfg_i.count != '0) && ((cfg_i.on != '0) || (cfg_i.off != '0));
            if (valid_d) begin
              // total = count * (on + off) - off
              req.start = 1'b1;
              req.op    = rabt_pkg::OP_MUL;
              state_d   = S_MUL;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            dt_d    = elapsed_i;
            state_d = S_ADD;
          end
        end
      end
      S_MUL: begin
        if (sts.done) begin
          state_d = S_TOTAL;
        end
      end
      S_TOTAL: begin
        total_d   = tot_diff;
        active_d  = (tot_diff != '0);
        playing_d = (tot_diff != '0) && (lat_on_q != '0);
        state_d   = S_DONE;
      end
      S_ADD: begin
        if (!active_q) begin
          state_d = S_DONE;
        end else begin
          if (playing_q) begin
            on_tmr_d = phase_sum;
          end else begin
            off_tmr_d = phase_sum;
          end
          if (phase_sum >= phase_lim) begin
            req.start = 1'b1;
            req.op    = rabt_pkg::OP_DIV;
            state_d   = S_DIV;
          end else begin
            state_d = S_OVER;
          end
        end
      end
      S_DIV: begin
        if (sts.done) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        // whole periods go to the tally; the remainder decides the phase
        if (playing_q) begin
          tally_d = tally_q + TW'(unit_bits) + TW'(cross_on);
          if (cross_on) begin
            off_tmr_d = rem - TM'(lat_on_q);
            on_tmr_d  = '0;
            playing_d = 1'b0;
          end else begin
            on_tmr_d = rem;
          end
        end else begin
          tally_d = tally_q + TW'(unit_bits);
          if (cross_off) begin
            on_tmr_d  = rem - TM'(lat_off_q);
            off_tmr_d = '0;
            playing_d = 1'b1;
          end else begin
            off_tmr_d = rem;
          end
        end
        state_d = S_OVER;
      end
      S_OVER: begin
        // saturate at the total and end the burst there
        if (over_sum >= {1'b0, total_q}) begin
          overall_d = total_q;
          active_d  = 1'b0;
        end else begin
          overall_d = over_sum[TT-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= 1'b0;
      playing_q <= 1'b0;
      valid_q   <= 1'b0;
      total_q   <= '0;
      overall_q <= '0;
      on_tmr_q  <= '0;
      off_tmr_q <= '0;
      tally_q   <= '0;
      lat_on_q  <= '0;
      lat_off_q <= '0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      playing_q <= playing_d;
      valid_q   <= valid_d;
      total_q   <= total_d;
      overall_q <= overall_d;
      on_tmr_q  <= on_tmr_d;
      off_tmr_q <= off_tmr_d;
      tally_q   <= tally_d;
      lat_on_q  <= lat_on_d;
      lat_off_q <= lat_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q <= dt_d;
  end

  rabt_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .sts_o  (sts),
    .acc_o  (unit_acc),
    .bits_o (unit_bits)
  );

  assign item_ready_o        = in_idle;
  assign res_valid_o         = (state_q == S_DONE);
  assign res_o.active        = active_q;
  assign res_o.playing       = playing_q;
  assign res_o.plays_done    = tally_q;
  assign res_o.setup_valid   = valid_q;

endmodule

// ----- hw/rtl/repeated_action_burst_timer.sv -----
`timescale 1ns / 1ps

// Burst timer that alternates on and off phases for a programmed number of
// repetitions. Program repeat_count, on_time and off_time over the APB port
// (byte addresses 0, 4, 8), then send a start transfer (tuser = 1); each tick
// transfer (tuser = 0) carries the time elapsed since the previous one. Every
// input transfer yields one result transfer with the state after it. Items are
// handled one at a time by a single shift-and-add unit that does one bit per
// cycle: a start runs a 16-bit multiply for the total length, unless the
// settings are rejected; a tick does nothing while no burst runs, and runs
// the 18-step divide by the period only when a phase boundary is crossed. The
// next input is taken while a result still waits in the output register.
module repeated_action_burst_timer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rabt_pkg::ADDR_W-1:0]       paddr,
  input  logic [rabt_pkg::DATA_W-1:0]       pwdata,
  output logic [rabt_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] elapsed
  input  logic                              s_axis_tuser,   // [0] command
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata    // [0] active, [1] playing,
                                                            // [33:2] plays_done,
                                                            // [34] setup_valid
);

  localparam int TB = rabt_pkg::TIME_BITS;

  rabt_pkg::cfg_t     cfg_q, cfg_d;
  rabt_pkg::result_t  res;
  logic               res_valid, res_ready;
  logic               out_valid_q;
  rabt_pkg::result_t  out_q;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        rabt_pkg::REG_COUNT: cfg_d.count = pwdata[TB-1:0];
        rabt_pkg::REG_ON:    cfg_d.on    = pwdata[TB-1:0];
        rabt_pkg::REG_OFF:   cfg_d.off   = pwdata[TB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rabt_pkg::REG_COUNT: prdata = rabt_pkg::DATA_W'(cfg_q.count);
      rabt_pkg::REG_ON:    prdata = rabt_pkg::DATA_W'(cfg_q.on);
      rabt_pkg::REG_OFF:   prdata = rabt_pkg::DATA_W'(cfg_q.off);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rabt_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .elapsed_i    (s_axis_tdata[TB-1:0]),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // hold the result until the downstream transfer completes
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.setup_valid, out_q.plays_done,
                          out_q.playing, out_q.active};

endmodule

// ----- verif/repeated_action_burst_timer_tb.sv -----
`timescale 1ns / 1ps

module repeated_action_burst_timer_tb;

  localparam int         ADDR_W     = rabt_pkg::ADDR_W;
  localparam int         DATA_W     = rabt_pkg::DATA_W;
  localparam int         TOT_W      = rabt_pkg::TOT_W;
  localparam int         TMR_W      = rabt_pkg::TMR_W;
  localparam int         TALLY_W    = rabt_pkg::TALLY_W;
  localparam logic       CMD_TICK   = 1'b0;
  localparam logic       CMD_START  = 1'b1;
  localparam logic [1:0] REG_NONE   = 2'd3;   // unmapped word
  localparam int         RAND_ITEMS = 1800;
  localparam int         CYCLE_CAP  = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic        pready;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;

  repeated_action_burst_timer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [15:0] elapsed
    .s_axis_tuser (s_axis_tuser),   // [0] command
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // [0] active, [1] playing, [33:2] plays_done,
                                    // [34] setup_valid
  );

  always #2 clk_i = ~clk_i;

  // burst state as the block should hold it
  logic [15:0]        cfg_count = '0, cfg_on = '0, cfg_off = '0;
  logic [15:0]        lat_count = '0, lat_on = '0, lat_off = '0;
  logic               burst_active = 1'b0, burst_playing = 1'b0, burst_valid = 1'b0;
  logic [TOT_W-1:0]   total_len = '0, overall_t = '0;
  logic [TMR_W-1:0]   on_t = '0, off_t = '0;
  logic [TALLY_W-1:0] tally = '0;

  rabt_pkg::result_t burst_results[$];
  rabt_pkg::result_t got, want;
  bit          stall_on = 1'b1;
  int          rx_hold = 0;
  int          err_cnt = 0;
  int          cycles = 0;
  int          n_starts = 0, n_valid = 0, n_ticks = 0, n_checked = 0, n_settings = 0;

  function automatic void report(string what, longint unsigned exp_v, longint unsigned act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
    err_cnt++;
  endfunction

  // advance the burst by one item and return the state that follows it
  function automatic rabt_pkg::result_t burst_step(logic cmd, logic [15:0] dt);
    logic [TMR_W-1:0] per;
    rabt_pkg::result_t r;
    if (cmd == CMD_START) begin
      n_starts++;
      overall_t = '0;
      on_t      = '0;
      off_t     = '0;
      tally     = '0;
      total_len = '0;
      lat_count = cfg_count;
      lat_on    = cfg_on;
      lat_off   = cfg_off;
      if (lat_count != 0)
        total_len = TOT_W'(lat_count) * TOT_W'(lat_on)
                  + TOT_W'(lat_count - 16'd1) * TOT_W'(lat_off);
      burst_valid   = (lat_count != 0) && (lat_on != 0 || lat_off != 0);
      burst_active  = burst_valid && total_len != 0;
      burst_playing = burst_active && lat_on != 0;
      if (burst_valid) n_valid++;
    end else begin
      n_ticks++;
      per = TMR_W'(lat_on) + TMR_W'(lat_off);
      if (burst_active && per != 0) begin
        if (burst_playing) begin
          on_t = on_t + TMR_W'(dt);
          if (on_t >= lat_on) begin
            // fold whole periods into the tally
            tally = tally + TALLY_W'(on_t / per);
            on_t  = on_t % per;
            if (on_t >= lat_on) begin
              tally         = tally + 1;
              off_t         = on_t - TMR_W'(lat_on);
              on_t          = '0;
              burst_playing = 1'b0;
            end
          end
        end else begin
          off_t = off_t + TMR_W'(dt);
          if (off_t >= lat_off) begin
            tally = tally + TALLY_W'(off_t / per);
            off_t = off_t % per;
            if (off_t >= lat_off) begin
              on_t          = off_t - TMR_W'(lat_off);
              off_t         = '0;
              burst_playing = 1'b1;
            end
          end
        end
        overall_t = overall_t + TOT_W'(dt);
        if (overall_t >= total_len) begin
          overall_t    = total_len;
          burst_active = 1'b0;
        end
      end
    end
    r.active      = burst_active;
    r.playing     = burst_playing;
    r.plays_done  = tally;
    r.setup_valid = burst_valid;
    return r;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};   // upper half must be dropped
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      rabt_pkg::REG_COUNT: cfg_count = val;
      rabt_pkg::REG_ON:    cfg_on    = val;
      rabt_pkg::REG_OFF:   cfg_off   = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_check(input logic [1:0] idx);
    logic [DATA_W-1:0] exp_v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      rabt_pkg::REG_COUNT: exp_v = DATA_W'(cfg_count);
      rabt_pkg::REG_ON:    exp_v = DATA_W'(cfg_on);
      default:             exp_v = DATA_W'(cfg_off);
    endcase
    if (prdata !== exp_v) report("prdata", exp_v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic cmd, input logic [15:0] dt);
    int gap;
    gap = stall_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dt;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_results.push_back(burst_step(cmd, dt));
  endtask

  // drop tvalid and hold until every result is back
  task automatic wait_results;
    s_axis_tvalid <= 1'b0;
    while (burst_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_burst(input logic [15:0] cnt, input logic [15:0] on,
                           input logic [15:0] off);
    cfg_write(rabt_pkg::REG_COUNT, cnt);
    cfg_write(rabt_pkg::REG_ON, on);
    cfg_write(rabt_pkg::REG_OFF, off);
    n_settings++;
  endtask

  task automatic test_idle_ticks;
    // nothing latched yet: ticks do nothing, a start with zero count is rejected
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_START, 16'hFFFF);
    wait_results();
  endtask

  task automatic test_registers;
    cfg_check(rabt_pkg::REG_COUNT);
    cfg_check(rabt_pkg::REG_ON);
    cfg_check(rabt_pkg::REG_OFF);
    cfg_write(rabt_pkg::REG_COUNT, 16'hFFFF);
    cfg_write(rabt_pkg::REG_ON, 16'h0000);
    cfg_write(rabt_pkg::REG_OFF, 16'($urandom));
    cfg_check(rabt_pkg::REG_COUNT);
    cfg_check(rabt_pkg::REG_ON);
    cfg_check(rabt_pkg::REG_OFF);
    cfg_write(REG_NONE, 16'h5A5A);
    cfg_check(rabt_pkg::REG_COUNT);
    cfg_check(rabt_pkg::REG_ON);
    cfg_check(rabt_pkg::REG_OFF);
  endtask

  task automatic test_special_cases;
    set_burst(16'd3, 16'd0, 16'd0);        // both phases empty
    send_item(CMD_START, 16'($urandom));
    send_item(CMD_TICK, 16'd1);
    wait_results();
    set_burst(16'd0, 16'd5, 16'd5);        // no repetitions
    send_item(CMD_START, 16'($urandom));
    wait_results();
    set_burst(16'd1, 16'd0, 16'd7);        // valid but zero total
    send_item(CMD_START, 16'($urandom));
    send_item(CMD_TICK, 16'd9);
    wait_results();
    set_burst(16'd3, 16'd4, 16'd2);
    send_item(CMD_START, 16'($urandom));
    send_item(CMD_TICK, 16'd1);
    send_item(CMD_TICK, 16'd3);
    send_item(CMD_TICK, 16'd2);
    wait_results();
    cfg_write(rabt_pkg::REG_ON, 16'd9);    // latched copy must stay in use
    send_item(CMD_TICK, 16'd13);
    send_item(CMD_TICK, 16'hFFFF);
    wait_results();
    set_burst(16'd2, 16'd0, 16'd5);        // never plays
    send_item(CMD_START, 16'($urandom));
    send_item(CMD_TICK, 16'd12);
    wait_results();
    set_burst(16'd2, 16'd5, 16'd0);        // no gap
    send_item(CMD_START, 16'($urandom));
    send_item(CMD_TICK, 16'd7);
    wait_results();
    set_burst(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_START, 16'($urandom));
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_TICK, 16'hFFFE);
    wait_results();
    set_burst(16'd100, 16'd3, 16'd2);      // one tick runs past the end
    send_item(CMD_START, 16'($urandom));
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_TICK, 16'd5);
    wait_results();
  endtask

  task automatic test_random_bursts;
    int sent, n, phase, lim, pick;
    logic [15:0] v;
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      stall_on = ($urandom_range(0, 3) != 0);
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 15))
          0:       v = 16'h0000;
          1:       v = 16'hFFFF;
          2:       v = 16'($urandom);
          default: v = 16'($urandom_range(1, 12));
        endcase
        cfg_write(rabt_pkg::REG_COUNT, v);
      end
      repeat (2) begin
        if (phase == 0 || $urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 11))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom);
            default: v = 16'($urandom_range(1, 30));
          endcase
          cfg_write(($urandom_range(0, 1) != 0) ? rabt_pkg::REG_ON : rabt_pkg::REG_OFF, v);
        end
      end
      n_settings++;
      if ($urandom_range(0, 3) == 0) cfg_check(2'($urandom_range(0, 2)));
      // mostly a fresh start, now and then carry on from the previous burst
      if ($urandom_range(0, 9) != 0) begin
        send_item(CMD_START, 16'($urandom));
        sent++;
      end
      n = $urandom_range(4, 40);
      repeat (n) begin
        lim = (int'(lat_on) + int'(lat_off)) * 2 + 1;
        if (lim > 65535) lim = 65535;
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 24) == 0)
          send_item(CMD_START, 16'($urandom));
        else if (pick == 0)
          send_item(CMD_TICK, 16'h0000);
        else if (pick <= 4)
          send_item(CMD_TICK, 16'($urandom));
        else if (pick == 5)
          send_item(CMD_TICK, 16'hFFFF);
        else
          send_item(CMD_TICK, 16'($urandom_range(0, lim)));
        sent++;
      end
      wait_results();
      phase++;
    end
  endtask

  // result side: check each transfer and draw a stall after it
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[34:0];
      if (burst_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %0h", $time, got);
        err_cnt++;
      end else begin
        want = burst_results.pop_front();
        n_checked++;
        if (got.active !== want.active) report("active", want.active, got.active);
        if (got.playing !== want.playing) report("playing", want.playing, got.playing);
        if (got.plays_done !== want.plays_done)
          report("plays_done", want.plays_done, got.plays_done);
        if (got.setup_valid !== want.setup_valid)
          report("setup_valid", want.setup_valid, got.setup_valid);
      end
      rx_hold = stall_on ? $urandom_range(0, 7) : 0;
      if (rx_hold != 0) m_axis_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold--;
      if (rx_hold == 0) m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               burst_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;
    m_axis_tready <= 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_registers();
    test_special_cases();
    test_random_bursts();
    repeat (40) @(posedge clk_i);
    $display("covered %0d starts (%0d valid) and %0d ticks over %0d settings,",
             n_starts, n_valid, n_ticks, n_settings);
    $display("with %0d results compared against the burst model", n_checked);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rabt_pkg.sv
hw/rtl/rabt_unit.sv
hw/rtl/rabt_core.sv
hw/rtl/repeated_action_burst_timer.sv
verif/repeated_action_burst_timer_tb.sv
